/* hdl/tga_pkg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// TGA RLE row decoder package
// Shared widths, reset values, status codes and the result word layout.
// -----------------------------------------------------------------------------
package tga_pkg;

    localparam int unsigned ROW_W        = 18;
    localparam int unsigned BPP_W        = 3;
    localparam int unsigned PIX_W        = 32;
    localparam int unsigned REP_W        = 8;
    localparam int unsigned CFG_IDX_W    = 1;
    localparam int unsigned CFG_DATA_W   = 18;
    localparam int unsigned NEED_W       = 11;

    localparam int unsigned MAX_BYTES_PER_PIXEL = 4;

    localparam logic [BPP_W-1:0] BPP_RESET       = 3'd3;
    localparam logic [ROW_W-1:0] ROW_BYTES_RESET = 18'd3;

    localparam logic [7:0] RUN_FLAG_MASK  = 8'h80;
    localparam logic [7:0] PKT_COUNT_MASK = 8'h7f;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_OVERRUN  = 2'd1;
    localparam t_status ST_TRUNC    = 2'd2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_BYTES_PER_PIXEL = 1'd0;
    localparam t_cfg_idx REG_ROW_BYTES       = 1'd1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic [REP_W-1:0] repeat_count;
        logic             row_done;
        t_status          status;
    } t_result;

endpackage
`default_nettype wire

/* hdl/tga_in_if.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// TGA compressed byte channel
// Valid/ready channel that carries one stream byte or an end-of-stream mark.
// -----------------------------------------------------------------------------
interface tga_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface
`default_nettype wire

/* hdl/tga_out_if.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// TGA decoded pixel channel
// Valid/ready channel that carries one decoded pixel or run, or an error word.
// -----------------------------------------------------------------------------
interface tga_out_if;
    logic                      valid;
    logic                      ready;
    logic [tga_pkg::PIX_W-1:0] pixel_value;
    logic [tga_pkg::REP_W-1:0] repeat_count;
    logic                      row_done;
    tga_pkg::t_status          status;

    modport source (output valid, output pixel_value, output repeat_count,
                    output row_done, output status, input ready);
    modport sink   (input valid, input pixel_value, input repeat_count,
                    input row_done, input status, output ready);
endinterface
`default_nettype wire

/* hdl/tga_cfg_if.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// TGA configuration write channel
// Valid/ready channel that carries a register index and its write data.
// -----------------------------------------------------------------------------
interface tga_cfg_if;
    logic                           valid;
    logic                           ready;
    tga_pkg::t_cfg_idx              index;
    logic [tga_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hdl/tga_decode.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// TGA packet decoder
// Holds the row and packet state and works out, for one accepted word, the
// next state and at most one result.
// -----------------------------------------------------------------------------
module tga_decode (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic [7:0]                   i_data_byte,
    input  wire logic                         i_stream_end,
    input  wire logic                         i_cfg_write,
    input  wire logic [tga_pkg::BPP_W-1:0]    i_bpp,
    input  wire logic [tga_pkg::ROW_W-1:0]    i_row_bytes,
    input  wire logic [tga_pkg::ROW_W-1:0]    i_row_bytes_next,
    output logic                              o_res_valid,
    output tga_pkg::t_result                  o_res
);

    logic [tga_pkg::ROW_W-1:0] r_left, n_left;
    logic                      r_run, n_run;
    logic [7:0]                r_ppl, n_ppl;
    logic [1:0]                r_idx, n_idx;
    logic [tga_pkg::PIX_W-1:0] r_asm, n_asm;

    logic [7:0]                 count;
    logic [tga_pkg::NEED_W-1:0] need;
    logic [tga_pkg::PIX_W-1:0]  asm_new;
    logic [7:0]                 ppl_after;
    logic                       row_start;

    assign count     = (i_data_byte & tga_pkg::PKT_COUNT_MASK) + 8'd1;
    assign need      = {3'd0, count} * {8'd0, i_bpp};
    assign asm_new   = r_asm | ({24'd0, i_data_byte} << {r_idx, 3'b000});
    assign ppl_after = r_run ? 8'd0 : r_ppl - 8'd1;
    assign row_start = (r_ppl == 8'd0) && (r_left == i_row_bytes);

    always_comb begin
        n_left      = r_left;
        n_run       = r_run;
        n_ppl       = r_ppl;
        n_idx       = r_idx;
        n_asm       = r_asm;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_cfg_write) begin
            n_left = i_row_bytes_next;
            n_run  = 1'b0;
            n_ppl  = 8'd0;
            n_idx  = 2'd0;
            n_asm  = '0;
        end else if (i_accept) begin
            if (i_stream_end) begin
                if (!row_start) begin
                    n_left       = i_row_bytes;
                    n_run        = 1'b0;
                    n_ppl        = 8'd0;
                    n_idx        = 2'd0;
                    n_asm        = '0;
                    o_res_valid  = 1'b1;
                    o_res.status = tga_pkg::ST_TRUNC;
                end
            end else if (r_ppl == 8'd0) begin
                // Header byte: the whole packet is charged against the row here.
                if ({7'd0, need} > r_left) begin
                    n_left       = i_row_bytes;
                    n_run        = 1'b0;
                    n_idx        = 2'd0;
                    n_asm        = '0;
                    o_res_valid  = 1'b1;
                    o_res.status = tga_pkg::ST_OVERRUN;
                end else begin
                    n_left = r_left - {7'd0, need};
                    n_run  = (i_data_byte & tga_pkg::RUN_FLAG_MASK) != 8'd0;
                    n_ppl  = count;
                    n_idx  = 2'd0;
                    n_asm  = '0;
                end
            end else if (({1'b0, r_idx} + 3'd1) < i_bpp) begin
                n_idx = r_idx + 2'd1;
                n_asm = asm_new;
            end else begin
                o_res_valid        = 1'b1;
                o_res.pixel_value  = asm_new;
                o_res.repeat_count = r_run ? r_ppl : 8'd1;
                o_res.status       = tga_pkg::ST_OK;
                o_res.row_done     = (ppl_after == 8'd0) && (r_left == '0);
                n_ppl              = ppl_after;
                n_idx              = 2'd0;
                n_asm              = '0;
                if (o_res.row_done) begin
                    n_left = i_row_bytes;
                    n_run  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= tga_pkg::ROW_BYTES_RESET;
            r_run  <= 1'b0;
            r_ppl  <= 8'd0;
            r_idx  <= 2'd0;
            r_asm  <= '0;
        end else begin
            r_left <= n_left;
            r_run  <= n_run;
            r_ppl  <= n_ppl;
            r_idx  <= n_idx;
            r_asm  <= n_asm;
        end
    end

endmodule
`default_nettype wire

/* hdl/tga_result_reg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// TGA result register
// Output stage that holds one result word until the downstream side takes it.
// -----------------------------------------------------------------------------
module tga_result_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire tga_pkg::t_result  i_res,
    output logic                   o_can_load,
    tga_out_if.source              o_out
);

    logic             r_valid;
    tga_pkg::t_result r_res;

    // The stage can take a new word when it is empty or drains this cycle.
    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.pixel_value  = r_res.pixel_value;
    assign o_out.repeat_count = r_res.repeat_count;
    assign o_out.row_done     = r_res.row_done;
    assign o_out.status       = r_res.status;

endmodule
`default_nettype wire

/* hdl/tga_rle_row_decoder.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// TGA RLE row decoder
// Expands run-length coded TGA scanlines into pixels and pixel runs.
// -----------------------------------------------------------------------------
//  Port    Dir   Word
//  i_in    in    one compressed byte, or an end-of-stream mark
//  o_out   out   one pixel with repeat count, or an error status
//  i_cfg   in    register write: 0 bytes per pixel, 1 row bytes
//
// One byte is taken every cycle while the input is not stalled; a result is
// registered and appears in the cycle after the byte that completes it. Input
// stalls only while the output register is full and not being read. Config
// writes are always ready and restart the row.
// Reset is synchronous and leaves 3 bytes per pixel and a 3-byte row.
// -----------------------------------------------------------------------------
module tga_rle_row_decoder (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tga_in_if.sink    i_in,
    tga_out_if.source o_out,
    tga_cfg_if.sink   i_cfg
);

    logic [tga_pkg::BPP_W-1:0] r_bpp, n_bpp;
    logic [tga_pkg::ROW_W-1:0] r_row_bytes, n_row_bytes;
    logic [tga_pkg::BPP_W-1:0] bpp_eff;
    logic                      cfg_write;
    logic                      can_load;
    logic                      accept;
    logic                      res_valid;
    tga_pkg::t_result          res;

    assign i_cfg.ready = 1'b1;
    assign cfg_write   = i_cfg.valid;
    assign i_in.ready  = can_load;
    assign accept      = i_in.valid && can_load;

    always_comb begin
        n_bpp       = r_bpp;
        n_row_bytes = r_row_bytes;
        if (cfg_write) begin
            unique case (i_cfg.index)
                tga_pkg::REG_BYTES_PER_PIXEL: n_bpp = i_cfg.data[tga_pkg::BPP_W-1:0];
                tga_pkg::REG_ROW_BYTES:       n_row_bytes = i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp       <= tga_pkg::BPP_RESET;
            r_row_bytes <= tga_pkg::ROW_BYTES_RESET;
        end else begin
            r_bpp       <= n_bpp;
            r_row_bytes <= n_row_bytes;
        end
    end

    // Zero counts as one byte; anything past the widest pixel is clamped.
    always_comb begin
        if (r_bpp == '0) begin
            bpp_eff = tga_pkg::BPP_W'(1);
        end else if (r_bpp > tga_pkg::BPP_W'(tga_pkg::MAX_BYTES_PER_PIXEL)) begin
            bpp_eff = tga_pkg::BPP_W'(tga_pkg::MAX_BYTES_PER_PIXEL);
        end else begin
            bpp_eff = r_bpp;
        end
    end

    tga_decode u_decode (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_data_byte      (i_in.data_byte),
        .i_stream_end     (i_in.stream_end),
        .i_cfg_write      (cfg_write),
        .i_bpp            (bpp_eff),
        .i_row_bytes      (r_row_bytes),
        .i_row_bytes_next (n_row_bytes),
        .o_res_valid      (res_valid),
        .o_res            (res)
    );

    tga_result_reg u_result (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && res_valid),
        .i_res      (res),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire
